/* rtl/lsps_pkg.sv */
`default_nettype none
package lsps_pkg;

   // Encoding modes
   localparam logic [1:0] MODE_RAW    = 2'd0;
   localparam logic [1:0] MODE_HIBIT  = 2'd1;
   localparam logic [1:0] MODE_START  = 2'd2;
   localparam logic [1:0] MODE_PACKED = 2'd3;

   // Item kinds
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_IDLE  = 1'b1;

   // Control register indexes
   localparam logic CSR_STRIP_MODE = 1'b0;
   localparam logic CSR_LED_COUNT  = 1'b1;

   localparam int MODE_W  = 2;
   localparam int COUNT_W = 12;
   localparam int CSR_W   = 12;

   // Longest strip the latch length covers
   localparam int MAX_LEDS = 2048;

   // Latch zero bytes: at most 3 * ceil(MAX_LEDS / 192)
   localparam int LATCH_MAX = 3 * ((MAX_LEDS + 191) / 192);
   localparam int LATCH_W   = $clog2(LATCH_MAX + 1);

   localparam int QUEUE_DEPTH = 2;

   // Bit counts of a result
   localparam logic [3:0] BITS_BYTE   = 4'd8;
   localparam logic [3:0] BITS_SINGLE = 4'd1;

   // Header lengths
   localparam logic [2:0] HDR_START_BYTES  = 3'd6;
   localparam logic [2:0] HDR_PACKED_BYTES = 3'd2;
   localparam logic [1:0] HDR_START_BITS   = 2'd2;

   // Work descriptor for one item, counts of each kind of result in order
   typedef struct packed {
      logic [2:0]         pre_bytes;
      logic [1:0]         pre_bits;
      logic               start_bit;
      logic [1:0]         data_n;
      logic [23:0]        data;
      logic [LATCH_W-1:0] post_bytes;
   } desc_type;

endpackage
`default_nettype wire

/* rtl/lsps_front.sv */
`default_nettype none
module lsps_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic                        csr_index,
   input  wire logic [lsps_pkg::CSR_W-1:0]  csr_write_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_func,
   input  wire logic [7:0]                  req_red,
   input  wire logic [7:0]                  req_green,
   input  wire logic [7:0]                  req_blue,
   input  wire logic                        req_first_pixel,
   input  wire logic                        req_last_pixel,
   input  wire logic                        q_full,
   output logic                             q_push,
   output lsps_pkg::desc_type               q_desc
);
   import lsps_pkg::*;

   logic [MODE_W-1:0]  strip_mode_ff, strip_mode_in;
   logic [COUNT_W-1:0] led_count_ff, led_count_in;
   logic               in_frame_ff, in_frame_in;

   logic               accept;
   logic               emits;
   logic [COUNT_W-1:0] leds;
   logic [COUNT_W:0]   leds_up;
   logic [6:0]         blocks;
   logic [14:0]        scaled;
   logic [5:0]         groups;
   logic [6:0]         latch_sum;
   logic [LATCH_W-1:0] latch_bytes;
   logic [15:0]        word;
   desc_type           desc;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Latch length: 3 * ceil(leds/192), ceil(leds/192) = ceil(ceil(leds/64)/3), divide by 3 via *171>>9
   always_comb begin
      leds        = (led_count_ff > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS) : led_count_ff;
      leds_up     = {1'b0, leds} + (COUNT_W+1)'(63);
      blocks      = leds_up[COUNT_W:6];
      scaled      = 15'(blocks + 7'd2) * 15'd171;
      groups      = scaled[14:9];
      latch_sum   = {1'b0, groups} + {groups, 1'b0};
      latch_bytes = latch_sum[LATCH_W-1:0];
   end

   // Classify item into a descriptor
   always_comb begin
      word            = {1'b1, req_red[7:3], req_green[7:3], req_blue[7:3]};
      desc.pre_bytes  = 3'd0;
      desc.pre_bits   = 2'd0;
      desc.start_bit  = 1'b0;
      desc.data_n     = 2'd3;
      desc.data       = {req_red, req_green, req_blue};
      desc.post_bytes = '0;
      emits           = 1'b1;
      if (req_func == FUNC_IDLE) begin
         desc.data_n    = 2'd0;
         desc.pre_bytes = HDR_PACKED_BYTES;
         emits          = (strip_mode_ff == MODE_PACKED) && !in_frame_ff;
      end else begin
         unique case (strip_mode_ff)
            MODE_RAW: begin
            end
            MODE_HIBIT: begin
               desc.data = {1'b1, req_red[7:1], 1'b1, req_green[7:1], 1'b1, req_blue[7:1]};
               if (req_last_pixel) begin
                  desc.post_bytes = latch_bytes;
               end
            end
            MODE_START: begin
               desc.start_bit = 1'b1;
               if (req_first_pixel) begin
                  desc.pre_bytes = HDR_START_BYTES;
                  desc.pre_bits  = HDR_START_BITS;
               end
            end
            MODE_PACKED: begin
               desc.data_n = 2'd2;
               desc.data   = {word, 8'h00};
               if (req_first_pixel) begin
                  desc.pre_bytes = HDR_PACKED_BYTES;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign q_push = accept && emits;
   assign q_desc = desc;

   // Track frame and take register writes
   always_comb begin
      in_frame_in   = in_frame_ff;
      strip_mode_in = strip_mode_ff;
      led_count_in  = led_count_ff;
      if (accept && (req_func == FUNC_PIXEL)) begin
         in_frame_in = !req_last_pixel;
      end
      if (csr_write_en) begin
         if (csr_index == CSR_STRIP_MODE) begin
            strip_mode_in = csr_write_data[MODE_W-1:0];
         end else begin
            led_count_in = csr_write_data[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         strip_mode_ff <= MODE_RAW;
         led_count_ff  <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         strip_mode_ff <= strip_mode_in;
         led_count_ff  <= led_count_in;
      end
   end

`ifndef SYNTHESIS
   // Every pushed descriptor yields at least one result
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_desc.pre_bytes != 3'd0 || q_desc.data_n != 2'd0))
      else $error("empty descriptor pushed");
`endif

endmodule
`default_nettype wire

/* rtl/lsps_queue.sv */
`default_nettype none
module lsps_queue #(
   parameter int DEPTH = lsps_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lsps_pkg::desc_type  push_desc,
   output logic                     full,
   input  wire logic                pop,
   output logic                     q_valid,
   output lsps_pkg::desc_type       pop_desc
);
   import lsps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign q_valid  = (count_ff != '0);
   assign pop_desc = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed descriptor
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) pop |-> q_valid)
      else $error("queue underflow");
`endif

endmodule
`default_nettype wire

/* rtl/lsps_back.sv */
`default_nettype none
module lsps_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire lsps_pkg::desc_type  q_desc,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_out_bits,
   output logic [3:0]               rsp_bit_count,
   output logic                     rsp_run_end
);
   import lsps_pkg::*;

   desc_type   desc_ff, desc_in;
   logic       act_valid_ff, act_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_bits_ff;
   logic [3:0] bit_count_ff;
   logic       run_end_ff;

   logic       out_free;
   logic       gen;
   logic       done;
   logic [7:0] cur_bits;
   logic [3:0] cur_count;
   logic       cur_last;
   desc_type   step;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign gen      = act_valid_ff && out_free;
   assign done     = gen && cur_last;
   assign q_pop    = q_valid && (!act_valid_ff || done);

   // Pick the next result from the active descriptor
   always_comb begin
      step      = desc_ff;
      cur_bits  = 8'h00;
      cur_count = BITS_BYTE;
      priority if (desc_ff.pre_bytes != 3'd0) begin
         step.pre_bytes = desc_ff.pre_bytes - 3'd1;
      end else if (desc_ff.pre_bits != 2'd0) begin
         cur_count     = BITS_SINGLE;
         step.pre_bits = desc_ff.pre_bits - 2'd1;
      end else if (desc_ff.start_bit) begin
         cur_bits       = 8'h01;
         cur_count      = BITS_SINGLE;
         step.start_bit = 1'b0;
      end else if (desc_ff.data_n != 2'd0) begin
         cur_bits    = desc_ff.data[23:16];
         step.data   = {desc_ff.data[15:0], 8'h00};
         step.data_n = desc_ff.data_n - 2'd1;
      end else begin
         step.post_bytes = desc_ff.post_bytes - 1'b1;
      end
      cur_last = (step.pre_bytes == 3'd0) && (step.pre_bits == 2'd0) && !step.start_bit
                 && (step.data_n == 2'd0) && (step.post_bytes == '0);
   end

   // Load, advance or drop the active descriptor
   always_comb begin
      desc_in      = desc_ff;
      act_valid_in = act_valid_ff;
      if (q_pop) begin
         desc_in      = q_desc;
         act_valid_in = 1'b1;
      end else if (done) begin
         act_valid_in = 1'b0;
      end else if (gen) begin
         desc_in = step;
      end
      rsp_valid_in = gen || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_valid_ff <= act_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload, load a fresh result when the output register frees up
   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      if (gen) begin
         out_bits_ff  <= cur_bits;
         bit_count_ff <= cur_count;
         run_end_ff   <= cur_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_bits  = out_bits_ff;
   assign rsp_bit_count = bit_count_ff;
   assign rsp_run_end   = run_end_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(act_valid_ff)) |-> $past(done))
      else $error("descriptor dropped before its last result");
   assert property (@(posedge clock) disable iff (reset)
      gen |-> (cur_count == BITS_BYTE || cur_bits[7:1] == 7'd0))
      else $error("single bit result carries extra bits");
`endif

endmodule
`default_nettype wire

/* rtl/led_strip_pixel_serializer_core.sv */
// LED strip pixel serializer.
// Input channel req_*: one pixel (func = pixel, red/green/blue, first/last
// marks) or one idle tick, taken when req_valid is high and req_stall low.
// Result channel rsp_*: groups of bits to shift out MSB first, 8 bits or a
// single bit in bit 0; rsp_run_end marks the last group of each item.
// Control registers csr_*: index 0 strip mode, index 1 LED count; write
// them only while the block is idle.
// The first group of an item passes through the queue entry, the active
// descriptor register and the output register. Groups leave at one per cycle
// while rsp_stall is low, set by the output stage, so a pixel gives 3 groups
// in modes 0 and 1 (2 in mode 3, 4 in mode 2), up to 12 with a mode 2 header
// and up to 36 with a mode 1 latch. The front end classifies items into a
// short descriptor queue and keeps taking items while the back end works,
// until the queue is full. Reset clears the registers to mode 0 and count 0,
// closes the frame and empties the queue and output. A stalled result holds
// steady; the queue then fills and req_stall rises.
`default_nettype none
module led_strip_pixel_serializer_core #(
   parameter int QUEUE_DEPTH = lsps_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic                        csr_index,
   input  wire logic [lsps_pkg::CSR_W-1:0]  csr_write_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_func,
   input  wire logic [7:0]                  req_red,
   input  wire logic [7:0]                  req_green,
   input  wire logic [7:0]                  req_blue,
   input  wire logic                        req_first_pixel,
   input  wire logic                        req_last_pixel,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_out_bits,
   output logic [3:0]                       rsp_bit_count,
   output logic                             rsp_run_end
);
   import lsps_pkg::*;

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   desc_type push_desc;
   desc_type pop_desc;

   // Take and classify items
   lsps_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_first_pixel (req_first_pixel),
      .req_last_pixel  (req_last_pixel),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_desc          (push_desc)
   );

   // Buffer descriptors between the two sides
   lsps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .pop_desc  (pop_desc)
   );

   // Emit bit groups
   lsps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_desc        (pop_desc),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_bits  (rsp_out_bits),
      .rsp_bit_count (rsp_bit_count),
      .rsp_run_end   (rsp_run_end)
   );

endmodule
`default_nettype wire

/* sim/tb_led_strip_pixel_serializer_core.sv */
`timescale 1ns / 1ps

module tb_led_strip_pixel_serializer_core;
   import lsps_pkg::*;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 80;

   // One group of bits leaving the serializer
   typedef struct {
      logic [7:0] out_bits;
      logic [3:0] bit_count;
      logic       run_end;
   } bit_group_type;

   // Predicts the bit groups of each pixel or tick and checks them in order
   class strip_scoreboard;
      logic [MODE_W-1:0]  strip_mode = MODE_RAW;
      logic [COUNT_W-1:0] led_count  = '0;
      logic               in_frame   = 1'b0;
      bit_group_type      pending_groups[$];
      int                 errors     = 0;

      function void push_group(logic [7:0] bits, logic [3:0] cnt);
         bit_group_type g;
         g.out_bits  = bits;
         g.bit_count = cnt;
         g.run_end   = 1'b0;
         pending_groups.push_back(g);
      endfunction

      // Note an accepted item; return the number of groups it causes
      function int note_item(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic first, logic last);
         int         base;
         int         leds;
         int         latch_bytes;
         logic [15:0] word;
         base = pending_groups.size();
         if (func == FUNC_IDLE) begin
            if (strip_mode == MODE_PACKED && !in_frame) begin
               push_group(8'h00, BITS_BYTE);
               push_group(8'h00, BITS_BYTE);
            end
         end else begin
            case (strip_mode)
               MODE_RAW: begin
                  push_group(r, BITS_BYTE);
                  push_group(g, BITS_BYTE);
                  push_group(b, BITS_BYTE);
               end
               MODE_HIBIT: begin
                  push_group({1'b1, r[7:1]}, BITS_BYTE);
                  push_group({1'b1, g[7:1]}, BITS_BYTE);
                  push_group({1'b1, b[7:1]}, BITS_BYTE);
                  if (last) begin
                     // latch length saturates at the longest strip
                     leds = (led_count > MAX_LEDS) ? MAX_LEDS : int'(led_count);
                     latch_bytes = 3 * ((leds + 191) / 192);
                     repeat (latch_bytes) push_group(8'h00, BITS_BYTE);
                  end
               end
               MODE_START: begin
                  if (first) begin
                     repeat (HDR_START_BYTES) push_group(8'h00, BITS_BYTE);
                     repeat (HDR_START_BITS) push_group(8'h00, BITS_SINGLE);
                  end
                  push_group(8'h01, BITS_SINGLE);
                  push_group(r, BITS_BYTE);
                  push_group(g, BITS_BYTE);
                  push_group(b, BITS_BYTE);
               end
               default: begin
                  word = {1'b1, r[7:3], g[7:3], b[7:3]};
                  if (first) begin
                     repeat (HDR_PACKED_BYTES) push_group(8'h00, BITS_BYTE);
                  end
                  push_group(word[15:8], BITS_BYTE);
                  push_group(word[7:0], BITS_BYTE);
               end
            endcase
            in_frame = !last;
         end
         if (pending_groups.size() > base)
            pending_groups[pending_groups.size()-1].run_end = 1'b1;
         return pending_groups.size() - base;
      endfunction

      // Compare one accepted group against the oldest expectation
      function void check_group(logic [7:0] bits, logic [3:0] cnt, logic run_end);
         bit_group_type want;
         if (pending_groups.size() == 0) begin
            $error("unexpected group: out_bits %0h bit_count %0d run_end %0b",
                   bits, cnt, run_end);
            errors++;
            return;
         end
         want = pending_groups.pop_front();
         if (bits !== want.out_bits) begin
            $error("out_bits: expected %0h, actual %0h", want.out_bits, bits);
            errors++;
         end
         if (cnt !== want.bit_count) begin
            $error("bit_count: expected %0d, actual %0d", want.bit_count, cnt);
            errors++;
         end
         if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, actual %0b", want.run_end, run_end);
            errors++;
         end
      endfunction

      function int pending();
         return pending_groups.size();
      endfunction
   endclass

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               csr_write_en    = 1'b0;
   logic               csr_index       = CSR_STRIP_MODE;
   logic [CSR_W-1:0]   csr_write_data  = '0;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_func        = FUNC_PIXEL;
   logic [7:0]         req_red         = '0;
   logic [7:0]         req_green       = '0;
   logic [7:0]         req_blue        = '0;
   logic               req_first_pixel = 1'b0;
   logic               req_last_pixel  = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [7:0]         rsp_out_bits;
   logic [3:0]         rsp_bit_count;
   logic               rsp_run_end;

   strip_scoreboard    sb = new();
   int                 cycles       = 0;
   int                 useful_items = 0;
   bit                 quiet        = 1'b0;
   int                 hold_asks    = 0;
   int                 hold_done    = 0;
   int                 hold_left    = 0;
   int                 stall_left   = 0;
   int                 run_left     = 0;

   led_strip_pixel_serializer_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_first_pixel (req_first_pixel),
      .req_last_pixel  (req_last_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_bits    (rsp_out_bits),
      .rsp_bit_count   (rsp_bit_count),
      .rsp_run_end     (rsp_run_end)
   );

   always #1 clock = ~clock;

   // Watch both channels and bound the run
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (sb.note_item(req_func, req_red, req_green, req_blue,
                             req_first_pixel, req_last_pixel) > 0)
               useful_items++;
         end
         if (rsp_valid && !rsp_stall)
            sb.check_group(rsp_out_bits, rsp_bit_count, rsp_run_end);
      end
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stall bursts, long hold-offs on request, none when quiet
   always @(posedge clock) begin
      if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = LONG_HOLD;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 6);
         else
            run_left = $urandom_range(1, 16);
         rsp_stall <= 1'b0;
      end
   end

   // Offer one item and hold it until taken
   task automatic send_item(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic first, logic last);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_first_pixel <= first;
      req_last_pixel  <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid for a random burst now and then
   task automatic pace(int gap_pct);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected group has come out
   task automatic drain();
      req_valid <= 1'b0;
      // let the monitor note the item taken at the last edge
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CSR_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_STRIP_MODE)
         sb.strip_mode = data[MODE_W-1:0];
      else
         sb.led_count = data[COUNT_W-1:0];
   endtask

   task automatic set_config(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
      drain();
      write_reg(CSR_STRIP_MODE, CSR_W'(mode));
      write_reg(CSR_LED_COUNT, CSR_W'(count));
   endtask

   // Mostly well-formed frames, with idle ticks and some loose items mixed in
   task automatic send_stream(int target, int gap_pct, bit pause_mid);
      int goal;
      int half;
      int len;
      bit paused;
      goal   = useful_items + target;
      half   = useful_items + target / 2;
      paused = 1'b0;
      while (useful_items < goal) begin
         if (pause_mid && !paused && useful_items >= half) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 15) begin
            send_item(($urandom_range(0, 3) == 0) ? FUNC_IDLE : FUNC_PIXEL,
                      8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom));
            pace(gap_pct);
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_item(FUNC_IDLE, 8'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom), 1'($urandom));
                  pace(gap_pct);
               end
               send_item(FUNC_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                         i == 0, i == len - 1);
               pace(gap_pct);
            end
         end
      end
   endtask

   task automatic run_phase(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count,
                            int target, int gap_pct, bit long_hold, bit pause_mid);
      set_config(mode, count);
      if (long_hold)
         hold_asks++;
      send_stream(target, gap_pct, pause_mid);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset state: raw bytes, idle tick gives nothing
      send_item(FUNC_PIXEL, 8'h00, 8'hFF, 8'hA5, 1'b1, 1'b1);
      send_item(FUNC_IDLE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);

      // High-bit mode: no latch at zero count, saturated, just past one group
      set_config(MODE_HIBIT, 12'd0);
      send_item(FUNC_PIXEL, 8'hFF, 8'h00, 8'h80, 1'b1, 1'b1);
      set_config(MODE_HIBIT, 12'hFFF);
      send_item(FUNC_PIXEL, 8'h01, 8'hFE, 8'h7F, 1'b1, 1'b1);
      set_config(MODE_HIBIT, 12'd193);
      send_item(FUNC_PIXEL, 8'h55, 8'hAA, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_PIXEL, 8'hAA, 8'h55, 8'hFF, 1'b0, 1'b1);
      set_config(MODE_HIBIT, 12'd2048);
      send_item(FUNC_PIXEL, 8'h80, 8'h01, 8'hFF, 1'b1, 1'b1);

      // Start-bit mode: header, first mark inside an open frame, loose pixel
      set_config(MODE_START, 12'd1);
      send_item(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      send_item(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_PIXEL, 8'h12, 8'h34, 8'h56, 1'b1, 1'b0);
      send_item(FUNC_PIXEL, 8'h78, 8'h9A, 8'hBC, 1'b0, 1'b1);
      send_item(FUNC_IDLE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_PIXEL, 8'hDE, 8'hAD, 8'hBE, 1'b0, 1'b0);

      // Packed mode: zero words outside a frame, none inside
      set_config(MODE_PACKED, 12'd4095);
      send_item(FUNC_IDLE, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1);
      send_item(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      send_item(FUNC_IDLE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
      send_item(FUNC_PIXEL, 8'h07, 8'hF8, 8'h00, 1'b0, 1'b1);
      send_item(FUNC_IDLE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
      send_item(FUNC_PIXEL, 8'h00, 8'h07, 8'hF8, 1'b0, 1'b0);
      send_item(FUNC_PIXEL, 8'hF8, 8'h00, 8'h07, 1'b1, 1'b0);
      send_item(FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);

      // Random phases across modes and latch lengths
      run_phase(MODE_RAW, 12'($urandom), 30, 25, 1'b0, 1'b0);
      run_phase(MODE_HIBIT, 12'd0, 20, 25, 1'b0, 1'b0);
      run_phase(MODE_HIBIT, 12'hFFF, 20, 0, 1'b0, 1'b0);
      run_phase(MODE_HIBIT, 12'($urandom_range(1, 600)), 30, 25, 1'b0, 1'b1);
      run_phase(MODE_START, 12'($urandom), 30, 25, 1'b1, 1'b0);
      run_phase(MODE_PACKED, 12'($urandom), 30, 25, 1'b0, 1'b1);
      run_phase(MODE_HIBIT, 12'd192, 20, 0, 1'b1, 1'b0);
      run_phase(MODE_START, 12'($urandom), 20, 25, 1'b0, 1'b0);

      // Closing stretch at full rate on both sides
      quiet = 1'b1;
      run_phase(MODE_PACKED, 12'($urandom), 25, 0, 1'b0, 1'b0);
      run_phase(MODE_HIBIT, 12'($urandom_range(1, 2048)), 20, 0, 1'b0, 1'b0);

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/lsps_pkg.sv
rtl/lsps_front.sv
rtl/lsps_queue.sv
rtl/lsps_back.sv
rtl/led_strip_pixel_serializer_core.sv
sim/tb_led_strip_pixel_serializer_core.sv
